FILE: hdl/mi3_pkg.sv
package mi3_pkg;

  // Element format: signed Q16.16
  localparam int ElemW = 32;
  localparam int FracBits = 16;
  localparam int NumElem = 9;

  // Cofactor of 32-bit elements: difference of two products, each
  // truncated by FracBits, fits in 49 signed bits
  localparam int CofW = 49;
  localparam int CofMagW = CofW - 1;

  // Intermediate magnitude limit 2^61 - 1
  localparam int DmagW = 61;
  localparam logic [DmagW-1:0] InterMax = '1;

  // Reciprocal floor(2^62 / |det|) needs 63 bits
  localparam int RecipW = 63;
  localparam int RecipShift = RecipW - 1 - FracBits;

  // Pipeline depths of the sub-units
  localparam int CofLat = 2;
  localparam int DetLat = 5;
  localparam int ScaleLat = 5;

  localparam int EpsW = 31;

  typedef logic signed [ElemW-1:0] elem_t;
  typedef logic signed [CofW-1:0] cof_t;
  typedef logic [DmagW-1:0] dmag_t;
  typedef logic [RecipW-1:0] recip_t;

  typedef struct packed {
    logic det_neg;
    logic singular;
  } det_flags_t;

  // Source elements (a, b, c, d) of each adjugate entry: a*b - c*d
  localparam logic [3:0] CofSrc [NumElem][4] = '{
    '{4'd4, 4'd8, 4'd5, 4'd7},
    '{4'd2, 4'd7, 4'd1, 4'd8},
    '{4'd1, 4'd5, 4'd2, 4'd4},
    '{4'd5, 4'd6, 4'd3, 4'd8},
    '{4'd0, 4'd8, 4'd2, 4'd6},
    '{4'd2, 4'd3, 4'd0, 4'd5},
    '{4'd3, 4'd7, 4'd4, 4'd6},
    '{4'd1, 4'd6, 4'd0, 4'd7},
    '{4'd0, 4'd4, 4'd1, 4'd3}
  };

endpackage

FILE: hdl/mi3_cof.sv
module mi3_cof (
  input  logic           clk,
  input  logic           en,
  input  mi3_pkg::elem_t a,
  input  mi3_pkg::elem_t b,
  input  mi3_pkg::elem_t c,
  input  mi3_pkg::elem_t d,
  output mi3_pkg::cof_t  cof
);

  logic signed [2*mi3_pkg::ElemW-1:0] p_ab;
  logic signed [2*mi3_pkg::ElemW-1:0] p_cd;
  logic signed [2*mi3_pkg::ElemW-1:0] rnd_ab;
  logic signed [2*mi3_pkg::ElemW-1:0] rnd_cd;
  logic signed [2*mi3_pkg::ElemW-mi3_pkg::FracBits-1:0] q_ab;
  logic signed [2*mi3_pkg::ElemW-mi3_pkg::FracBits-1:0] q_cd;

  // Form both exact products
  always_ff @(posedge clk) begin
    if (en) begin
      p_ab <= a * b;
      p_cd <= c * d;
    end
  end

  // Truncate toward zero: bias negative products before the shift
  always_comb begin
    rnd_ab = p_ab + {{(2*mi3_pkg::ElemW-mi3_pkg::FracBits){1'b0}},
                     {mi3_pkg::FracBits{p_ab[2*mi3_pkg::ElemW-1]}}};
    rnd_cd = p_cd + {{(2*mi3_pkg::ElemW-mi3_pkg::FracBits){1'b0}},
                     {mi3_pkg::FracBits{p_cd[2*mi3_pkg::ElemW-1]}}};
    q_ab = rnd_ab[2*mi3_pkg::ElemW-1:mi3_pkg::FracBits];
    q_cd = rnd_cd[2*mi3_pkg::ElemW-1:mi3_pkg::FracBits];
  end

  // Subtract; the range fits, no saturation needed
  always_ff @(posedge clk) begin
    if (en) begin
      cof <= mi3_pkg::CofW'(q_ab) - mi3_pkg::CofW'(q_cd);
    end
  end

endmodule

FILE: hdl/mi3_det.sv
module mi3_det (
  input  logic                        clk,
  input  logic                        en,
  input  logic [mi3_pkg::EpsW-1:0]    det_epsilon,
  input  mi3_pkg::elem_t              a [3],
  input  mi3_pkg::cof_t               c [3],
  output mi3_pkg::dmag_t              dmag,
  output mi3_pkg::det_flags_t         flags
);

  localparam int AW = mi3_pkg::ElemW;
  localparam int CW = mi3_pkg::CofMagW;
  localparam int HalfW = CW / 2;
  localparam int FullW = AW + CW;
  localparam int QW = FullW - mi3_pkg::FracBits;
  localparam int PW = mi3_pkg::DmagW + 2;
  localparam int SW = PW + 2;

  logic [AW-1:0]          am   [3];
  logic [CW-1:0]          cm   [3];
  logic                   sn1  [3];
  logic [AW+HalfW-1:0]    pl   [3];
  logic [AW+HalfW-1:0]    ph   [3];
  logic                   sn2  [3];
  logic signed [PW-1:0]   p3   [3];
  logic [FullW-1:0]       full [3];
  logic [QW-1:0]          q    [3];
  logic [mi3_pkg::DmagW-1:0] qs [3];
  logic signed [SW-1:0]   sum;
  logic signed [SW-1:0]   lim;
  logic signed [PW-1:0]   det_next;
  logic signed [PW-1:0]   det;
  logic [PW-1:0]          det_mag;

  // Take magnitudes and product signs
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        am[i]  <= a[i][AW-1] ? AW'(-a[i]) : AW'(a[i]);
        cm[i]  <= c[i][mi3_pkg::CofW-1] ? CW'(-c[i]) : CW'(c[i]);
        sn1[i] <= a[i][AW-1] ^ c[i][mi3_pkg::CofW-1];
      end
    end
  end

  // Two partial products per lane
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        pl[i]  <= am[i] * cm[i][HalfW-1:0];
        ph[i]  <= am[i] * cm[i][CW-1:HalfW];
        sn2[i] <= sn1[i];
      end
    end
  end

  // Merge partials, drop fraction, saturate, restore sign
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      full[i] = FullW'(pl[i]) + (FullW'(ph[i]) << HalfW);
      q[i] = full[i][FullW-1:mi3_pkg::FracBits];
      qs[i] = (q[i] > QW'(mi3_pkg::InterMax)) ? mi3_pkg::InterMax
                                               : q[i][mi3_pkg::DmagW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        p3[i] <= sn2[i] ? -$signed(PW'(qs[i])) : $signed(PW'(qs[i]));
      end
    end
  end

  // Sum the three terms and saturate
  always_comb begin
    sum = SW'(p3[0]) + SW'(p3[1]) + SW'(p3[2]);
    lim = $signed(SW'(mi3_pkg::InterMax));
    if (sum > lim) begin
      det_next = PW'(lim);
    end else if (sum < -lim) begin
      det_next = PW'(-lim);
    end else begin
      det_next = PW'(sum);
    end
    det_mag = det[PW-1] ? PW'(-det) : PW'(det);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      det <= det_next;
    end
  end

  // Magnitude and singular test
  always_ff @(posedge clk) begin
    if (en) begin
      dmag <= det_mag[mi3_pkg::DmagW-1:0];
      flags.det_neg <= det[PW-1];
      flags.singular <= (det_mag == '0) ||
                        (det_mag < PW'(det_epsilon));
    end
  end

endmodule

FILE: hdl/mi3_recip.sv
module mi3_recip (
  input  logic            clk,
  input  logic            en,
  input  mi3_pkg::dmag_t  d,
  output mi3_pkg::recip_t recip
);

  localparam int N = mi3_pkg::RecipW;
  localparam int DW = mi3_pkg::DmagW;

  // One quotient bit per stage, most significant first
  logic [DW-1:0]   rem_q [N];
  logic [DW-1:0]   div_q [N];
  logic [N-1:0]    quo_q [N];
  logic [DW:0]     trial [N];
  logic [DW:0]     diff  [N];
  logic [DW-1:0]   dk    [N];
  logic            take  [N];

  always_comb begin
    for (int k = 0; k < N; k++) begin
      if (k == 0) begin
        trial[k] = (DW+1)'(1);
        dk[k] = d;
      end else begin
        trial[k] = {rem_q[k-1], 1'b0};
        dk[k] = div_q[k-1];
      end
      diff[k] = trial[k] - {1'b0, dk[k]};
      take[k] = trial[k] >= {1'b0, dk[k]};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < N; k++) begin
        rem_q[k] <= take[k] ? diff[k][DW-1:0] : trial[k][DW-1:0];
        div_q[k] <= dk[k];
        if (k == 0) begin
          quo_q[k] <= N'(take[k]);
        end else begin
          quo_q[k] <= {quo_q[k-1][N-2:0], take[k]};
        end
      end
    end
  end

  assign recip = quo_q[N-1];

endmodule

FILE: hdl/mi3_scale.sv
module mi3_scale (
  input  logic            clk,
  input  logic            en,
  input  mi3_pkg::cof_t   adj,
  input  logic            det_neg,
  input  mi3_pkg::recip_t recip,
  output mi3_pkg::elem_t  inv
);

  localparam int CW = mi3_pkg::CofMagW;
  localparam int AH = CW / 2;
  localparam int RL = 32;
  localparam int RH = mi3_pkg::RecipW - RL;
  localparam int SW = CW + RL;
  localparam int TW = CW + mi3_pkg::RecipW + 1;
  localparam int QW = TW - mi3_pkg::RecipShift;
  localparam int EW = mi3_pkg::ElemW;

  logic [CW-1:0]     am;
  mi3_pkg::recip_t   rcp;
  logic              neg1, neg2, neg3, neg4;
  logic [AH+RL-1:0]  p00, p10;
  logic [AH+RH-1:0]  p01, p11;
  logic [SW-1:0]     sa, sb;
  logic [TW-1:0]     total;
  logic [QW-1:0]     q;
  logic [QW-1:0]     lim;
  logic [EW-1:0]     mag;

  // Magnitude, result sign and reciprocal of the same item
  always_ff @(posedge clk) begin
    if (en) begin
      am   <= adj[mi3_pkg::CofW-1] ? CW'(-adj) : CW'(adj);
      neg1 <= adj[mi3_pkg::CofW-1] ^ det_neg;
      rcp  <= recip;
    end
  end

  // Four partial products
  always_ff @(posedge clk) begin
    if (en) begin
      p00  <= am[AH-1:0] * rcp[RL-1:0];
      p01  <= am[AH-1:0] * rcp[mi3_pkg::RecipW-1:RL];
      p10  <= am[CW-1:AH] * rcp[RL-1:0];
      p11  <= am[CW-1:AH] * rcp[mi3_pkg::RecipW-1:RL];
      neg2 <= neg1;
    end
  end

  // Combine in pairs
  always_ff @(posedge clk) begin
    if (en) begin
      sa   <= SW'(p00) + (SW'(p10) << AH);
      sb   <= SW'(p01) + (SW'(p11) << AH);
      neg3 <= neg2;
    end
  end

  // Final sum, drop fraction, saturate to the element range
  always_comb begin
    total = TW'(sa) + (TW'(sb) << RL);
    q = total[TW-1:mi3_pkg::RecipShift];
    lim = neg3 ? (QW'(1) << (EW-1)) : ((QW'(1) << (EW-1)) - QW'(1));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mag  <= (q > lim) ? lim[EW-1:0] : q[EW-1:0];
      neg4 <= neg3;
    end
  end

  // Apply sign
  always_ff @(posedge clk) begin
    if (en) begin
      inv <= neg4 ? -$signed(mag) : $signed(mag);
    end
  end

endmodule

FILE: hdl/matrix_inverse_3x3.sv
// 3x3 matrix inverse by adjugate and determinant reciprocal.
// Input channel s_*: one item is a row-major matrix of nine signed Q16.16
// elements in s_tdata, element 00 in the lowest 32 bits. Output channel
// m_*: nine inverse elements in m_tdata in the same order, saturated to
// Q16.16, and the singular flag in m_tuser; a singular item has all nine
// elements zero.
// Throughput: one item per cycle while the output is not stalled. The pipeline
// runs through the cofactor and determinant lanes, the 63-stage restoring
// reciprocal divider (one quotient bit per stage) and the scaling lanes.
// The whole pipeline advances together; it holds only while a result sits
// in the output register and m_tready is low, and s_tready is low exactly
// then. Items in flight are never dropped.
// det_epsilon is written through cfg_wr_en / cfg_wr_data; the user must do so
// only while no item is in flight, as the block itself does not enforce it.
// Reset (rst, synchronous) empties the pipeline and sets det_epsilon to
// 66 (about 0.001).
module matrix_inverse_3x3 (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [287:0] s_tdata,   // in_00, in_01, in_02, in_10 .. in_22
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [287:0] m_tdata,   // inv_00, inv_01, inv_02, inv_10 .. inv_22
  output logic [0:0]   m_tuser,   // singular
  input  logic         cfg_wr_en,
  input  logic [30:0]  cfg_wr_data
);

  localparam int NE = mi3_pkg::NumElem;
  localparam int EW = mi3_pkg::ElemW;
  localparam int DetAt = mi3_pkg::CofLat + mi3_pkg::DetLat;
  localparam int RecipAt = DetAt + mi3_pkg::RecipW;
  localparam int AdjDly = RecipAt - mi3_pkg::CofLat;
  localparam int FlagDly = RecipAt - DetAt;
  localparam int SingDly = FlagDly + mi3_pkg::ScaleLat;
  localparam int Lat = RecipAt + mi3_pkg::ScaleLat;

  logic                     en;
  logic [mi3_pkg::EpsW-1:0] det_epsilon;
  logic [Lat-1:0]           vld;
  mi3_pkg::elem_t           m [NE];
  mi3_pkg::cof_t            adj [NE];
  mi3_pkg::elem_t           row0_dly [mi3_pkg::CofLat][3];
  mi3_pkg::cof_t            det_c [3];
  mi3_pkg::dmag_t           dmag;
  mi3_pkg::det_flags_t      flags;
  mi3_pkg::det_flags_t      flg_dly [SingDly];
  mi3_pkg::cof_t            adj_dly [AdjDly][NE];
  mi3_pkg::recip_t          recip;
  mi3_pkg::elem_t           inv [NE];

  assign en = !m_tvalid || m_tready;
  assign s_tready = en;

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      det_epsilon <= mi3_pkg::EpsW'(66);
    end else if (cfg_wr_en) begin
      det_epsilon <= cfg_wr_data;
    end
  end

  // Unpack elements
  always_comb begin
    for (int i = 0; i < NE; i++) begin
      m[i] = s_tdata[EW*i +: EW];
    end
  end

  // Nine cofactor lanes
  for (genvar g = 0; g < NE; g++) begin : g_cof
    mi3_cof u_cof (
      .clk (clk),
      .en  (en),
      .a   (m[mi3_pkg::CofSrc[g][0]]),
      .b   (m[mi3_pkg::CofSrc[g][1]]),
      .c   (m[mi3_pkg::CofSrc[g][2]]),
      .d   (m[mi3_pkg::CofSrc[g][3]]),
      .cof (adj[g])
    );
  end

  // Align the first row with the cofactors
  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < 3; j++) begin
        row0_dly[0][j] <= m[j];
      end
      for (int k = 1; k < mi3_pkg::CofLat; k++) begin
        row0_dly[k] <= row0_dly[k-1];
      end
    end
  end

  assign det_c[0] = adj[0];
  assign det_c[1] = adj[3];
  assign det_c[2] = adj[6];

  // Merge: determinant by first-row expansion
  mi3_det u_det (
    .clk         (clk),
    .en          (en),
    .det_epsilon (det_epsilon),
    .a           (row0_dly[mi3_pkg::CofLat-1]),
    .c           (det_c),
    .dmag        (dmag),
    .flags       (flags)
  );

  mi3_recip u_recip (
    .clk   (clk),
    .en    (en),
    .d     (dmag),
    .recip (recip)
  );

  // Hold adjugate and flags until the reciprocal is ready
  always_ff @(posedge clk) begin
    if (en) begin
      adj_dly[0] <= adj;
      for (int k = 1; k < AdjDly; k++) begin
        adj_dly[k] <= adj_dly[k-1];
      end
      flg_dly[0] <= flags;
      for (int k = 1; k < SingDly; k++) begin
        flg_dly[k] <= flg_dly[k-1];
      end
    end
  end

  // Nine scaling lanes
  for (genvar g = 0; g < NE; g++) begin : g_scale
    mi3_scale u_scale (
      .clk     (clk),
      .en      (en),
      .adj     (adj_dly[AdjDly-1][g]),
      .det_neg (flg_dly[FlagDly-1].det_neg),
      .recip   (recip),
      .inv     (inv[g])
    );
  end

  // Advance item valid marks
  always_ff @(posedge clk) begin
    if (rst) begin
      vld      <= '0;
      m_tvalid <= 1'b0;
    end else if (en) begin
      vld      <= {vld[Lat-2:0], s_tvalid};
      m_tvalid <= vld[Lat-1];
    end
  end

  // Output register; drop elements of a singular item
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < NE; i++) begin
        m_tdata[EW*i +: EW] <= flg_dly[SingDly-1].singular ? '0 : inv[i];
      end
      m_tuser[0] <= flg_dly[SingDly-1].singular;
    end
  end

endmodule

FILE: verif/mi3_checker.sv
module mi3_checker (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  input  logic         s_tready,
  input  logic [287:0] s_tdata,
  input  logic         m_tvalid,
  input  logic         m_tready,
  input  logic [287:0] m_tdata,
  input  logic [0:0]   m_tuser,
  input  logic         cfg_wr_en,
  input  logic [30:0]  cfg_wr_data,
  output int           fail_count,
  output int           pending
);

  localparam logic [63:0] SatLim = (64'd1 << 61) - 64'd1;

  typedef struct {
    logic [287:0] elems;
    logic         singular;
  } inverse_t;

  inverse_t    inverse_q[$];
  logic [30:0] epsilon;

  function automatic logic [63:0] magnitude(logic signed [63:0] x);
    return x < 0 ? -x : x;
  endfunction

  // Fixed-point product, truncated toward zero, saturated to the wide format
  function automatic logic signed [63:0] fx_mul(logic signed [63:0] a,
                                                logic signed [63:0] b);
    logic [127:0] p;
    logic [127:0] q;
    p = magnitude(a) * magnitude(b);
    q = p >> mi3_pkg::FracBits;
    if (q > SatLim) q = SatLim;
    return ((a < 0) != (b < 0)) ? -$signed({1'b0, q[62:0]}) : $signed({1'b0, q[62:0]});
  endfunction

  function automatic logic signed [63:0] clamp_wide(logic signed [63:0] x);
    if (x > $signed(SatLim)) return SatLim;
    if (x < -$signed(SatLim)) return -$signed(SatLim);
    return x;
  endfunction

  function automatic logic signed [63:0] cofactor(logic signed [63:0] a, logic signed [63:0] b,
                                                  logic signed [63:0] c, logic signed [63:0] d);
    return clamp_wide(fx_mul(a, b) - fx_mul(c, d));
  endfunction

  function automatic inverse_t invert(logic [287:0] data, logic [30:0] eps);
    logic signed [63:0] m [9];
    logic signed [63:0] adj [9];
    logic signed [63:0] det;
    logic [63:0]        dmag;
    logic [63:0]        recip;
    logic [127:0]       p;
    logic [127:0]       q;
    logic               neg;
    inverse_t           r;
    for (int i = 0; i < 9; i++) m[i] = $signed(data[32*i +: 32]);
    adj[0] = cofactor(m[4], m[8], m[5], m[7]);
    adj[3] = cofactor(m[5], m[6], m[3], m[8]);
    adj[6] = cofactor(m[3], m[7], m[4], m[6]);
    det = clamp_wide(fx_mul(m[0], adj[0]) + fx_mul(m[1], adj[3]) + fx_mul(m[2], adj[6]));
    dmag = magnitude(det);
    r.elems = '0;
    r.singular = 1'b1;
    if (dmag == 0 || dmag < {33'd0, eps}) return r;
    adj[1] = cofactor(m[2], m[7], m[1], m[8]);
    adj[2] = cofactor(m[1], m[5], m[2], m[4]);
    adj[4] = cofactor(m[0], m[8], m[2], m[6]);
    adj[5] = cofactor(m[2], m[3], m[0], m[5]);
    adj[7] = cofactor(m[1], m[6], m[0], m[7]);
    adj[8] = cofactor(m[0], m[4], m[1], m[3]);
    recip = (64'd1 << 62) / dmag;
    r.singular = 1'b0;
    for (int i = 0; i < 9; i++) begin
      neg = (adj[i] < 0) != (det < 0);
      p = magnitude(adj[i]) * recip;
      q = p >> 46;
      if (neg && q > 128'h8000_0000) q = 128'h8000_0000;
      if (!neg && q > 128'h7fff_ffff) q = 128'h7fff_ffff;
      r.elems[32*i +: 32] = neg ? -q[31:0] : q[31:0];
    end
    return r;
  endfunction

  assign pending = inverse_q.size();

  // Track the threshold, queue predictions, compare results
  always @(posedge clk) begin
    inverse_t want;
    int       errs;
    errs = 0;
    if (rst) begin
      epsilon <= 31'd66;
      inverse_q.delete();
      fail_count <= 0;
    end else begin
      if (cfg_wr_en) epsilon <= cfg_wr_data;
      if (s_tvalid && s_tready) inverse_q.push_back(invert(s_tdata, epsilon));
      if (m_tvalid && m_tready) begin
        if (inverse_q.size() == 0) begin
          $error("result with nothing expected");
          errs++;
        end else begin
          want = inverse_q.pop_front();
          for (int i = 0; i < 9; i++)
            if (m_tdata[32*i +: 32] !== want.elems[32*i +: 32]) begin
              $error("inv_%0d%0d expected %h got %h", i / 3, i % 3,
                     want.elems[32*i +: 32], m_tdata[32*i +: 32]);
              errs++;
            end
          if (m_tuser[0] !== want.singular) begin
            $error("singular expected %b got %b", want.singular, m_tuser[0]);
            errs++;
          end
        end
      end
      fail_count <= fail_count + errs;
    end
  end
endmodule

FILE: verif/tb_matrix_inverse_3x3.sv
module tb_matrix_inverse_3x3;
  logic         clk;
  logic         rst;
  logic         s_tvalid;
  logic         s_tready;
  logic [287:0] s_tdata;
  logic         m_tvalid;
  logic         m_tready;
  logic [287:0] m_tdata;
  logic [0:0]   m_tuser;
  logic         cfg_wr_en;
  logic [30:0]  cfg_wr_data;
  int           fail_count;
  int           pending;
  int           send_idle_pct;
  int           recv_idle_pct;
  logic         hold_off;
  int           quiet_cycles;
  logic         timed_out;

  localparam int Latency = 76;
  localparam int WatchLimit = 20000;

  matrix_inverse_3x3 uut (.*);

  mi3_checker checker_i (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Receiver: random stalls, plus a long hold-off on request
  initial begin
    m_tready = 1'b0;
    forever begin
      @(posedge clk);
      m_tready <= !hold_off && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Watchdog on cycles with no handshake
  initial begin
    quiet_cycles = 0;
    timed_out = 1'b0;
    forever begin
      @(posedge clk);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || rst) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WatchLimit) begin
        timed_out = 1'b1;
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  function automatic logic [31:0] rand_elem();
    case ($urandom_range(7))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'h0;
      3: return $urandom();
      4: return {{12{1'($urandom_range(1))}}, 20'($urandom())};
      default: return {{14{1'($urandom_range(1))}}, 18'($urandom())};
    endcase
  endfunction

  // Offer one item and hold it until accepted
  task automatic send_matrix(logic [287:0] data);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= data;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (Latency + 10) @(posedge clk);
  endtask

  task automatic write_eps(logic [30:0] val);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [287:0] diag(logic [31:0] a, logic [31:0] b, logic [31:0] c);
    logic [287:0] d;
    d = '0;
    d[31:0] = a;
    d[159:128] = b;
    d[287:256] = c;
    return d;
  endfunction

  initial begin
    logic [287:0] mtx;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    hold_off = 1'b0;
    send_idle_pct = 17;
    recv_idle_pct = 65;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: identity, scaled, zero, extremes, tiny determinant
    send_matrix(diag(32'h1_0000, 32'h1_0000, 32'h1_0000));
    send_matrix(diag(32'hffff_0000, 32'h2_0000, 32'h0_8000));
    send_matrix('0);
    send_matrix({9{32'h7fff_ffff}});
    send_matrix({9{32'h8000_0000}});
    send_matrix(diag(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff));
    send_matrix(diag(32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff));
    send_matrix(diag(32'h1, 32'h1, 32'h1));
    send_matrix(diag(32'h100, 32'h100, 32'h100));
    send_matrix(diag(32'h10, 32'h1_0000, 32'h1_0000));
    send_matrix(diag(32'h0_0041, 32'h1_0000, 32'h1_0000));
    send_matrix(diag(32'h0_0042, 32'h1_0000, 32'h1_0000));
    send_matrix({32'h9_0000, 32'h8_0000, 32'h7_0000, 32'h6_0000, 32'h5_0000,
                 32'h4_0000, 32'h3_0000, 32'h2_0000, 32'h1_0000});
    drain();

    // Zero threshold: only exact zero determinant is singular; then the largest threshold
    write_eps(31'd0);
    send_matrix('0);
    send_matrix(diag(32'h1, 32'h1, 32'h1));
    send_matrix(diag(32'h100, 32'h100, 32'h100));
    drain();
    write_eps(31'h7fff_ffff);
    send_matrix(diag(32'h7fff_ffff, 32'h1_0000, 32'h1_0000));
    send_matrix(diag(32'h7fff_ffff, 32'h7fff_ffff, 32'h1_0000));
    drain();

    // Random phases with varying thresholds and idle patterns
    for (int ph = 0; ph < 7; ph++) begin
      case (ph)
        0: write_eps(31'd66);
        1: write_eps(31'($urandom()));
        2: write_eps(31'd1);
        3: write_eps(31'($urandom_range(65535)));
        default: write_eps(31'($urandom_range(300)));
      endcase
      send_idle_pct = (ph < 3) ? 17 : (ph < 5) ? 65 : 0;
      recv_idle_pct = (ph < 3) ? 65 : (ph < 5) ? 17 : 0;
      for (int n = 0; n < 200; n++) begin
        for (int i = 0; i < 9; i++) mtx[32*i +: 32] = rand_elem();
        if (ph == 5 && n == 20) begin
          hold_off = 1'b1;
          fork
            begin
              repeat (300) @(posedge clk);
              hold_off = 1'b0;
            end
          join_none
        end
        send_matrix(mtx);
      end
      drain();
    end

    if (fail_count == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end
endmodule
